// ----- sv/gcl_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and sequencer states for the grid cell-list engine.
// No dependencies.
package gcl_pkg;

	localparam int MAX_GRID      = 32;
	localparam int MAX_PARTICLES = 4096;
	localparam int CELLS         = MAX_GRID * MAX_GRID;
	localparam int CELL_W        = $clog2(CELLS);
	localparam int AXIS_W        = $clog2(MAX_GRID);
	localparam int GRID_W        = 6;
	localparam int PID_W         = $clog2(MAX_PARTICLES);
	localparam int OFF_W         = PID_W + 1;
	localparam int POS_W         = 16;
	localparam int SCALE_W       = 22;
	localparam int PROD_W        = POS_W + SCALE_W;
	localparam int CFG_IDX_W     = 1;

	// request modes
	localparam logic [2:0] MODE_INSERT = 3'd0;
	localparam logic [2:0] MODE_BUILD  = 3'd1;
	localparam logic [2:0] MODE_QUERY  = 3'd2;
	localparam logic [2:0] MODE_READ   = 3'd3;
	localparam logic [2:0] MODE_CLEAR  = 3'd4;

	// result status
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_BUILT = 2'd2;
	localparam logic [1:0] ST_RANGE     = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_SCALE = 1'b1;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CLR,
		S_INS_X,
		S_INS_Y,
		S_INS_G,
		S_INS_RD,
		S_INS_WR,
		S_BLD_RD,
		S_BLD_WR,
		S_BLD_END,
		S_BLD_PRD,
		S_BLD_PCELL,
		S_BLD_PWR,
		S_BLD_DONE,
		S_Q_START,
		S_Q_CELL,
		S_Q_DIV,
		S_Q_NB,
		S_Q_EMIT,
		S_RD_START,
		S_RD_ID,
		S_RD_OUT
	} state_t;

endpackage

// ----- sv/grid_cell_list_neighbor_search_top.sv -----
`timescale 1ns / 1ps
// Grid cell-list binning engine: insert, counting-sort build, neighbor query,
// sorted read and clear under one sequencer. Depends on gcl_pkg.
//
// Usage:
//   A request is taken on a rising edge with start high and busy low; mode,
//   pos_x, pos_y, particle_index and position are sampled then. busy stays
//   high until the request is finished. Each result is shown for one cycle
//   with valid high, never two in a row within a query; last marks the final
//   result of a request. The receiver cannot stall, so results are never held.
//   Config writes (cfg_write, cfg_index, cfg_data) land on the next edge and
//   are only legal while busy is low.
// Unused modes finish at once with no result. Per request (one shared 16x22
// multiplier; memories with one write port and registered reads, the offset
//   table with two read ports): insert scales x, y, forms the cell, bumps its
//   count, or ends at once if full; read gets the sorted id, then its cell;
//   clear zeroes one count entry per cycle; build sums counts to offsets, then
//   places each particle; query checks, gets cell/G, then up to 9 neighbors.
// Reset: config returns to grid_size 20 and cell_scale 20, the store empties,
//   and a sweep zeroes all 1024 per-cell counts with busy high.
module grid_cell_list_neighbor_search_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [2:0]                         mode,
	input  logic [gcl_pkg::POS_W-1:0]          pos_x,
	input  logic [gcl_pkg::POS_W-1:0]          pos_y,
	input  logic [gcl_pkg::PID_W-1:0]          particle_index,
	input  logic [gcl_pkg::PID_W-1:0]          position,
	input  logic                               cfg_write,
	input  logic [gcl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gcl_pkg::SCALE_W-1:0]        cfg_data,
	output logic                               valid,
	output logic [1:0]                         status,
	output logic [gcl_pkg::CELL_W-1:0]         cell_index,
	output logic [gcl_pkg::OFF_W-1:0]          range_start,
	output logic [gcl_pkg::OFF_W-1:0]          range_end,
	output logic [gcl_pkg::PID_W-1:0]          particle_id,
	output logic                               last
);

	localparam int CW = gcl_pkg::CELL_W;
	localparam int AW = gcl_pkg::AXIS_W;
	localparam int GW = gcl_pkg::GRID_W;
	localparam int PW = gcl_pkg::PID_W;
	localparam int OW = gcl_pkg::OFF_W;

	gcl_pkg::state_t state_q, state_d;

	// config
	logic [GW-1:0] grid_size_q;
	logic [gcl_pkg::SCALE_W-1:0] cell_scale_q;
	logic [GW-1:0] g;
	logic [CW:0] ncell;

	// control / datapath registers
	logic accept;
	logic [OW-1:0] total_q, built_total_q, acc_q;
	logic built_q, clr_emit_q, ok_q;
	logic [gcl_pkg::POS_W-1:0] pos_x_q, pos_y_q;
	logic [PW-1:0] pid_q, posn_q, p_q, id_q;
	logic [AW-1:0] cx_q, cy_q;
	logic [CW-1:0] cell_q, rem_q, idx_q;
	logic [1:0] dxi_q, dyi_q, dxmax, dymax;
	logic [CW:0] ci_q, ci, ci_base;
	logic nb_valid, nb_last, x_ok, y_ok, full, clr_done;

	// shared multiplier
	logic [gcl_pkg::POS_W-1:0] mul_a;
	logic [gcl_pkg::SCALE_W-1:0] mul_b;
	logic [gcl_pkg::PROD_W-1:0] prod_q;

	// memories
	logic [CW-1:0] cop_mem [gcl_pkg::MAX_PARTICLES];
	logic cop_we;
	logic [PW-1:0] cop_waddr, cop_raddr;
	logic [CW-1:0] cop_wdata, cop_rd_q;

	logic [OW-1:0] cnt_mem [gcl_pkg::CELLS];
	logic cnt_we;
	logic [CW-1:0] cnt_waddr, cnt_raddr;
	logic [OW-1:0] cnt_wdata, cnt_rd_q;

	logic [OW-1:0] off_mem [gcl_pkg::CELLS + 1];
	logic off_we;
	logic [CW:0] off_waddr, off_raddr_a, off_raddr_b;
	logic [OW-1:0] off_wdata, off_rd_a_q, off_rd_b_q;

	logic [OW-1:0] fill_mem [gcl_pkg::CELLS];
	logic fill_we;
	logic [CW-1:0] fill_waddr, fill_raddr;
	logic [OW-1:0] fill_wdata, fill_rd_q;

	logic [PW-1:0] srt_mem [gcl_pkg::MAX_PARTICLES];
	logic srt_we;
	logic [PW-1:0] srt_waddr, srt_raddr, srt_wdata, srt_rd_q;

	// result
	logic emit, e_last;
	logic [1:0] e_status;
	logic [CW-1:0] e_cell;
	logic [OW-1:0] e_start, e_end;
	logic [PW-1:0] e_pid;
	logic valid_q, last_q;
	logic [1:0] status_q;
	logic [CW-1:0] cell_index_q;
	logic [OW-1:0] range_start_q, range_end_q;
	logic [PW-1:0] particle_id_q;

	// axis cell from a scaled position, clamped to the last cell
	function automatic logic [AW-1:0] clamp_cell(input logic [gcl_pkg::PROD_W-1:0] p,
	                                             input logic [GW-1:0] gg);
		logic [gcl_pkg::SCALE_W-1:0] c;
		logic [gcl_pkg::SCALE_W-1:0] lim;
		c   = p[gcl_pkg::PROD_W-1:gcl_pkg::POS_W];
		lim = gcl_pkg::SCALE_W'(gg) - gcl_pkg::SCALE_W'(1);
		return (c > lim) ? lim[AW-1:0] : c[AW-1:0];
	endfunction

	assign accept = start && (state_q == gcl_pkg::S_IDLE);
	assign busy   = (state_q != gcl_pkg::S_IDLE);

	// effective grid: 0 reads as 1, large values saturate
	always_comb begin
		if (grid_size_q == '0) begin
			g = GW'(1);
		end else if (grid_size_q > GW'(gcl_pkg::MAX_GRID)) begin
			g = GW'(gcl_pkg::MAX_GRID);
		end else begin
			g = grid_size_q;
		end
	end
	assign ncell = (CW+1)'(g) * (CW+1)'(g);

	assign full     = (total_q >= OW'(gcl_pkg::MAX_PARTICLES));
	assign clr_done = (idx_q == CW'(gcl_pkg::CELLS - 1));

	// neighbor walk: dxi/dyi run 0..2 for offsets -1..+1
	assign x_ok = !((dxi_q == 2'd0 && cx_q == '0) ||
	                (dxi_q == 2'd2 && ({1'b0, cx_q} + GW'(1)) >= g));
	assign y_ok = !((dyi_q == 2'd0 && cy_q == '0) ||
	                (dyi_q == 2'd2 && ({1'b0, cy_q} + GW'(1)) >= g));
	assign nb_valid = x_ok && y_ok;
	assign dxmax = (({1'b0, cx_q} + GW'(1)) < g) ? 2'd2 : 2'd1;
	assign dymax = (({1'b0, cy_q} + GW'(1)) < g) ? 2'd2 : 2'd1;
	assign nb_last = (dxi_q == dxmax) && (dyi_q == dymax);
	assign ci_base = {1'b0, cell_q} + (CW+1)'(dyi_q) - (CW+1)'(1);

	always_comb begin
		case (dxi_q)
			2'd0:    ci = ci_base - (CW+1)'(g);
			2'd2:    ci = ci_base + (CW+1)'(g);
			default: ci = ci_base;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gcl_pkg::S_IDLE: begin
				if (accept) begin
					case (mode)
						gcl_pkg::MODE_INSERT: state_d = gcl_pkg::S_INS_X;
						gcl_pkg::MODE_BUILD:  state_d = gcl_pkg::S_BLD_RD;
						gcl_pkg::MODE_QUERY:  state_d = gcl_pkg::S_Q_START;
						gcl_pkg::MODE_READ:   state_d = gcl_pkg::S_RD_START;
						gcl_pkg::MODE_CLEAR:  state_d = gcl_pkg::S_CLR;
						default:              state_d = gcl_pkg::S_IDLE;
					endcase
				end
			end
			gcl_pkg::S_CLR:       state_d = clr_done ? gcl_pkg::S_IDLE : gcl_pkg::S_CLR;
			gcl_pkg::S_INS_X:     state_d = full ? gcl_pkg::S_IDLE : gcl_pkg::S_INS_Y;
			gcl_pkg::S_INS_Y:     state_d = gcl_pkg::S_INS_G;
			gcl_pkg::S_INS_G:     state_d = gcl_pkg::S_INS_RD;
			gcl_pkg::S_INS_RD:    state_d = gcl_pkg::S_INS_WR;
			gcl_pkg::S_INS_WR:    state_d = gcl_pkg::S_IDLE;
			gcl_pkg::S_BLD_RD:    state_d = gcl_pkg::S_BLD_WR;
			gcl_pkg::S_BLD_WR:
				state_d = ({1'b0, idx_q} == ncell - (CW+1)'(1)) ? gcl_pkg::S_BLD_END
				                                               : gcl_pkg::S_BLD_RD;
			gcl_pkg::S_BLD_END:
				state_d = (total_q == '0) ? gcl_pkg::S_BLD_DONE : gcl_pkg::S_BLD_PRD;
			gcl_pkg::S_BLD_PRD:   state_d = gcl_pkg::S_BLD_PCELL;
			gcl_pkg::S_BLD_PCELL: state_d = gcl_pkg::S_BLD_PWR;
			gcl_pkg::S_BLD_PWR:
				state_d = (({1'b0, p_q} + OW'(1)) == total_q) ? gcl_pkg::S_BLD_DONE
				                                              : gcl_pkg::S_BLD_PRD;
			gcl_pkg::S_BLD_DONE:  state_d = gcl_pkg::S_IDLE;
			gcl_pkg::S_Q_START:
				state_d = (!built_q || {1'b0, pid_q} >= total_q) ? gcl_pkg::S_IDLE
				                                                 : gcl_pkg::S_Q_CELL;
			gcl_pkg::S_Q_CELL:
				state_d = ({1'b0, cop_rd_q} >= ncell) ? gcl_pkg::S_IDLE : gcl_pkg::S_Q_DIV;
			gcl_pkg::S_Q_DIV:
				state_d = (rem_q >= CW'(g)) ? gcl_pkg::S_Q_DIV : gcl_pkg::S_Q_NB;
			gcl_pkg::S_Q_NB:      state_d = nb_valid ? gcl_pkg::S_Q_EMIT : gcl_pkg::S_Q_NB;
			gcl_pkg::S_Q_EMIT:    state_d = nb_last ? gcl_pkg::S_IDLE : gcl_pkg::S_Q_NB;
			gcl_pkg::S_RD_START:
				state_d = (!built_q || {1'b0, posn_q} >= built_total_q) ? gcl_pkg::S_IDLE
				                                                        : gcl_pkg::S_RD_ID;
			gcl_pkg::S_RD_ID:     state_d = gcl_pkg::S_RD_OUT;
			gcl_pkg::S_RD_OUT:    state_d = gcl_pkg::S_IDLE;
			default:              state_d = gcl_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs: memory ports, multiplier operands, result
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		cop_we = 1'b0; cop_waddr = total_q[PW-1:0]; cop_wdata = cell_q; cop_raddr = pid_q;
		cnt_we = 1'b0; cnt_waddr = idx_q; cnt_wdata = '0; cnt_raddr = idx_q;
		off_we = 1'b0; off_waddr = {1'b0, idx_q}; off_wdata = acc_q;
		off_raddr_a = ci; off_raddr_b = ci + (CW+1)'(1);
		fill_we = 1'b0; fill_waddr = idx_q; fill_wdata = acc_q; fill_raddr = cop_rd_q;
		srt_we = 1'b0; srt_waddr = fill_rd_q[PW-1:0]; srt_wdata = p_q; srt_raddr = posn_q;
		emit = 1'b0; e_last = 1'b1; e_status = gcl_pkg::ST_OK;
		e_cell = '0; e_start = '0; e_end = '0; e_pid = '0;
		case (state_q)
			gcl_pkg::S_CLR: begin
				cnt_we = 1'b1;
				emit   = clr_done && clr_emit_q;
			end
			gcl_pkg::S_INS_X: begin
				mul_a = pos_x_q;
				mul_b = cell_scale_q;
				if (full) begin
					emit     = 1'b1;
					e_status = gcl_pkg::ST_FULL;
				end
			end
			gcl_pkg::S_INS_Y: begin
				mul_a = pos_y_q;
				mul_b = cell_scale_q;
			end
			gcl_pkg::S_INS_G: begin
				mul_a = gcl_pkg::POS_W'(cx_q);
				mul_b = gcl_pkg::SCALE_W'(g);
			end
			gcl_pkg::S_INS_RD: begin
				cnt_raddr = prod_q[CW-1:0] + CW'(cy_q);
			end
			gcl_pkg::S_INS_WR: begin
				cnt_we    = 1'b1;
				cnt_waddr = cell_q;
				cnt_wdata = cnt_rd_q + OW'(1);
				cop_we    = 1'b1;
				emit      = 1'b1;
				e_cell    = cell_q;
				e_pid     = total_q[PW-1:0];
			end
			gcl_pkg::S_BLD_WR: begin
				off_we  = 1'b1;
				fill_we = 1'b1;
			end
			gcl_pkg::S_BLD_END: begin
				off_we    = 1'b1;
				off_waddr = ncell;
			end
			gcl_pkg::S_BLD_PRD: begin
				cop_raddr = p_q;
			end
			gcl_pkg::S_BLD_PWR: begin
				if (ok_q && !fill_rd_q[OW-1]) begin
					srt_we     = 1'b1;
					fill_we    = 1'b1;
					fill_waddr = cell_q;
					fill_wdata = fill_rd_q + OW'(1);
				end
			end
			gcl_pkg::S_BLD_DONE: begin
				emit  = 1'b1;
				e_end = acc_q;
			end
			gcl_pkg::S_Q_START: begin
				e_pid = pid_q;
				if (!built_q) begin
					emit     = 1'b1;
					e_status = gcl_pkg::ST_NOT_BUILT;
				end else if ({1'b0, pid_q} >= total_q) begin
					emit     = 1'b1;
					e_status = gcl_pkg::ST_RANGE;
				end
			end
			gcl_pkg::S_Q_CELL: begin
				e_pid = pid_q;
				if ({1'b0, cop_rd_q} >= ncell) begin
					emit     = 1'b1;
					e_status = gcl_pkg::ST_RANGE;
				end
			end
			gcl_pkg::S_Q_EMIT: begin
				emit    = 1'b1;
				e_cell  = ci_q[CW-1:0];
				e_start = off_rd_a_q;
				e_end   = off_rd_b_q;
				e_pid   = pid_q;
				e_last  = nb_last;
			end
			gcl_pkg::S_RD_START: begin
				if (!built_q) begin
					emit     = 1'b1;
					e_status = gcl_pkg::ST_NOT_BUILT;
				end else if ({1'b0, posn_q} >= built_total_q) begin
					emit     = 1'b1;
					e_status = gcl_pkg::ST_RANGE;
				end
			end
			gcl_pkg::S_RD_ID: begin
				cop_raddr = srt_rd_q;
			end
			gcl_pkg::S_RD_OUT: begin
				emit   = 1'b1;
				e_cell = cop_rd_q;
				e_pid  = id_q;
			end
			default: begin
			end
		endcase
	end

	// control state; reset starts the count-clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= gcl_pkg::S_CLR;
			grid_size_q   <= GW'(20);
			cell_scale_q  <= gcl_pkg::SCALE_W'(20);
			total_q       <= '0;
			built_q       <= 1'b0;
			built_total_q <= '0;
			idx_q         <= '0;
			clr_emit_q    <= 1'b0;
			valid_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= emit;
			case (state_q)
				gcl_pkg::S_IDLE: begin
					idx_q      <= '0;
					clr_emit_q <= 1'b1;
				end
				gcl_pkg::S_CLR: begin
					idx_q <= idx_q + CW'(1);
					if (clr_done) begin
						total_q <= '0;
						built_q <= 1'b0;
					end
				end
				gcl_pkg::S_INS_WR: begin
					total_q <= total_q + OW'(1);
					built_q <= 1'b0;
				end
				gcl_pkg::S_BLD_WR: idx_q <= idx_q + CW'(1);
				gcl_pkg::S_BLD_DONE: begin
					built_q       <= 1'b1;
					built_total_q <= acc_q;
				end
				default: begin
				end
			endcase
			if (cfg_write) begin
				if (cfg_index == gcl_pkg::CFG_GRID_SIZE) begin
					grid_size_q <= cfg_data[GW-1:0];
					built_q     <= 1'b0;
				end else begin
					cell_scale_q <= cfg_data;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= gcl_pkg::PROD_W'(mul_a) * gcl_pkg::PROD_W'(mul_b);
		case (state_q)
			gcl_pkg::S_IDLE: begin
				pos_x_q <= pos_x;
				pos_y_q <= pos_y;
				pid_q   <= particle_index;
				posn_q  <= position;
				acc_q   <= '0;
				p_q     <= '0;
			end
			gcl_pkg::S_INS_Y:  cx_q <= clamp_cell(prod_q, g);
			gcl_pkg::S_INS_G:  cy_q <= clamp_cell(prod_q, g);
			gcl_pkg::S_INS_RD: cell_q <= prod_q[CW-1:0] + CW'(cy_q);
			gcl_pkg::S_BLD_WR: acc_q <= acc_q + cnt_rd_q;
			gcl_pkg::S_BLD_PCELL: begin
				cell_q <= cop_rd_q;
				ok_q   <= ({1'b0, cop_rd_q} < ncell);
			end
			gcl_pkg::S_BLD_PWR: p_q <= p_q + PW'(1);
			gcl_pkg::S_Q_CELL: begin
				cell_q <= cop_rd_q;
				rem_q  <= cop_rd_q;
				cx_q   <= '0;
			end
			gcl_pkg::S_Q_DIV: begin
				// cell / G by repeated subtraction
				if (rem_q >= CW'(g)) begin
					rem_q <= rem_q - CW'(g);
					cx_q  <= cx_q + AW'(1);
				end else begin
					cy_q  <= rem_q[AW-1:0];
					dxi_q <= 2'd0;
					dyi_q <= 2'd0;
				end
			end
			gcl_pkg::S_Q_NB: begin
				ci_q <= ci;
				if (!nb_valid) begin
					if (dyi_q == 2'd2) begin
						dyi_q <= 2'd0;
						dxi_q <= dxi_q + 2'd1;
					end else begin
						dyi_q <= dyi_q + 2'd1;
					end
				end
			end
			gcl_pkg::S_Q_EMIT: begin
				if (dyi_q == 2'd2) begin
					dyi_q <= 2'd0;
					dxi_q <= dxi_q + 2'd1;
				end else begin
					dyi_q <= dyi_q + 2'd1;
				end
			end
			gcl_pkg::S_RD_ID: id_q <= srt_rd_q;
			default: begin
			end
		endcase
		last_q         <= e_last;
		status_q       <= e_status;
		cell_index_q   <= e_cell;
		range_start_q  <= e_start;
		range_end_q    <= e_end;
		particle_id_q  <= e_pid;
	end

	// memories: one write and registered reads
	always_ff @(posedge clk) begin
		if (cop_we) cop_mem[cop_waddr] <= cop_wdata;
		cop_rd_q <= cop_mem[cop_raddr];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
		cnt_rd_q <= cnt_mem[cnt_raddr];
	end

	always_ff @(posedge clk) begin
		if (off_we) off_mem[off_waddr] <= off_wdata;
		off_rd_a_q <= off_mem[off_raddr_a];
		off_rd_b_q <= off_mem[off_raddr_b];
	end

	always_ff @(posedge clk) begin
		if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
		fill_rd_q <= fill_mem[fill_raddr];
	end

	always_ff @(posedge clk) begin
		if (srt_we) srt_mem[srt_waddr] <= srt_wdata;
		srt_rd_q <= srt_mem[srt_raddr];
	end

	assign valid        = valid_q;
	assign last         = last_q;
	assign status       = status_q;
	assign cell_index   = cell_index_q;
	assign range_start  = range_start_q;
	assign range_end    = range_end_q;
	assign particle_id  = particle_id_q;

endmodule

// ----- sv/gcl_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks on the grid cell-list engine, bound to the top level.
// Depends on gcl_pkg.
module gcl_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic [2:0]                  mode,
	input logic                        valid,
	input logic [1:0]                  status,
	input logic                        last
);

	// every defined mode keeps the engine busy the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (mode == gcl_pkg::MODE_INSERT || mode == gcl_pkg::MODE_BUILD ||
		 mode == gcl_pkg::MODE_QUERY || mode == gcl_pkg::MODE_READ ||
		 mode == gcl_pkg::MODE_CLEAR)) |=> busy)
		else $error("request taken but engine not busy");

	// a final result is never followed directly by another
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && last) |=> !valid)
		else $error("result right after last");

	// errors end the request
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && status != gcl_pkg::ST_OK) |-> last)
		else $error("error result not marked last");

	// more results pending means still busy
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !last) |-> busy)
		else $error("non-final result while idle");

	// idle engine produces nothing
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !valid)
		else $error("result while idle");

endmodule

bind grid_cell_list_neighbor_search_top gcl_checker u_gcl_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.mode   (mode),
	.valid  (valid),
	.status (status),
	.last   (last)
);
